FILE: sv/lrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types and constants for the link recovery supervisor: event codes,
// action codes, result codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package lrs_pkg;

  // configuration register data, index and limit widths, and event id width
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int LIMIT_W   = 4;
  localparam int ID_W      = 32;

  // event codes carried by opcode
  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_STATUS   = 3'd1,
    OP_RESTART  = 3'd2,
    OP_TICK     = 3'd3,
    OP_COMPLETE = 3'd4
  } op_t;

  // recovery actions, shared by action_now and done_action
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_PROBE = 3'd1,
    ACT_UART  = 3'd2,
    ACT_DOWN  = 3'd3,
    ACT_RADIO = 3'd4
  } act_t;

  // answer to a status event
  typedef enum logic [1:0] {
    BOOT_INVALID   = 2'd0,
    BOOT_FIRST     = 2'd1,
    BOOT_CHANGED   = 2'd2,
    BOOT_UNCHANGED = 2'd3
  } boot_res_t;

  // answer to a remote restart request
  typedef enum logic [2:0] {
    RR_BAD_BOOT  = 3'd0,
    RR_BAD_GEN   = 3'd1,
    RR_STALE     = 3'd2,
    RR_REFRESHED = 3'd3,
    RR_APPLIED   = 3'd4
  } restart_res_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STALE_AFTER    = 3'd0,
    REG_PROBE_INTERVAL = 3'd1,
    REG_PROBE_LIMIT    = 3'd2,
    REG_UART_AFTER     = 3'd3,
    REG_UNAVAIL_AFTER  = 3'd4
  } reg_idx_t;

  // configuration reset values
  localparam logic [CFG_W-1:0]   STALE_AFTER_RST    = 32'd5000;
  localparam logic [CFG_W-1:0]   PROBE_INTERVAL_RST = 32'd1000;
  localparam logic [LIMIT_W-1:0] PROBE_LIMIT_RST    = 4'd3;
  localparam logic [CFG_W-1:0]   UART_AFTER_RST     = 32'd10000;
  localparam logic [CFG_W-1:0]   UNAVAIL_AFTER_RST  = 32'd30000;

endpackage
`default_nettype wire

FILE: sv/link_recovery_supervisor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// link_recovery_supervisor
// Event-driven supervisor of a link partner: tracks status and boot id,
// queues remote radio restarts and escalates recovery actions on silence.
// ----------------------------------------------------------------------------
// One event is taken per clock cycle and its single result appears in the
// output register on the next cycle. All decision
// logic for an event (a few time subtractions and threshold compares against
// the state registers) sits between the input ports and the output register,
// and the state is updated on the same edge that accepts the event, so the
// next event sees it at once. The input side stalls only while a result is
// held in the output register and the output side stalls. Configuration
// writes are taken on any cycle (cfg_ready is always high) and must only be
// made while the block is idle.
// ----------------------------------------------------------------------------
module link_recovery_supervisor #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lrs_pkg::CFG_W-1:0]     cfg_data,
  // event channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [2:0]                    opcode,
  input  wire logic [TIME_WIDTH-1:0]         now_ms,
  input  wire logic [lrs_pkg::ID_W-1:0]      boot_id,
  input  wire logic [lrs_pkg::ID_W-1:0]      generation,
  input  wire logic                          fw_update,
  input  wire logic [2:0]                    done_action,
  input  wire logic                          succeeded,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         boot_result,
  output logic [2:0]                         restart_result,
  output logic [2:0]                         action_now,
  output logic                               complete_ok
);

  localparam int CMP_W = (TIME_WIDTH > lrs_pkg::CFG_W) ? TIME_WIDTH : lrs_pkg::CFG_W;

  // configuration registers
  logic [lrs_pkg::CFG_W-1:0]   stale_after_ms;
  logic [lrs_pkg::CFG_W-1:0]   probe_interval_ms;
  logic [lrs_pkg::LIMIT_W-1:0] probe_limit;
  logic [lrs_pkg::CFG_W-1:0]   uart_reinit_after_ms;
  logic [lrs_pkg::CFG_W-1:0]   unavailable_after_ms;

  // supervisor state
  logic [TIME_WIDTH-1:0]       monitor_start,      monitor_start_next;
  logic [TIME_WIDTH-1:0]       last_status_time,   last_status_time_next;
  logic [lrs_pkg::ID_W-1:0]    partner_boot,       partner_boot_next;
  logic [lrs_pkg::ID_W-1:0]    restart_generation, restart_generation_next;
  logic                        status_seen,        status_seen_next;
  logic                        restart_queued,     restart_queued_next;
  lrs_pkg::act_t               armed_action,       armed_action_next;
  logic [TIME_WIDTH-1:0]       action_issued_time, action_issued_time_next;
  logic [lrs_pkg::LIMIT_W-1:0] probes_done,        probes_done_next;
  logic [TIME_WIDTH-1:0]       last_probe_time,    last_probe_time_next;
  logic                        uart_reinit_done,   uart_reinit_done_next;
  logic                        marked_down,        marked_down_next;

  // result of the current event
  lrs_pkg::boot_res_t    res_boot;
  lrs_pkg::restart_res_t res_restart;
  lrs_pkg::act_t         res_action;
  logic                  res_complete;

  // shared time terms
  logic                  in_accept;
  logic                  time_ok;
  logic [TIME_WIDTH-1:0] silent;
  logic [TIME_WIDTH-1:0] probe_gap;
  logic [CMP_W-1:0]      silent_x;
  logic [CMP_W-1:0]      probe_gap_x;
  logic                  probe_due;
  logic                  uart_due;
  lrs_pkg::act_t         done_act;

  // handshakes
  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign done_act  = lrs_pkg::act_t'(done_action);

  // time window check and silence measures
  assign time_ok = (now_ms >= monitor_start) &&
                   !(status_seen && (now_ms < last_status_time));
  assign silent      = now_ms - (status_seen ? last_status_time : monitor_start);
  assign probe_gap   = now_ms - last_probe_time;
  assign silent_x    = CMP_W'(silent);
  assign probe_gap_x = CMP_W'(probe_gap);

  // escalation conditions for a tick
  assign probe_due = (probes_done < probe_limit) &&
                     (silent_x >= CMP_W'(stale_after_ms)) &&
                     ((probes_done == '0) ||
                      ((now_ms >= last_probe_time) &&
                       (probe_gap_x >= CMP_W'(probe_interval_ms))));
  assign uart_due  = (probes_done == probe_limit) && !uart_reinit_done &&
                     (silent_x >= CMP_W'(uart_reinit_after_ms));

  // event decode and next state
  always_comb begin
    monitor_start_next      = monitor_start;
    last_status_time_next   = last_status_time;
    partner_boot_next       = partner_boot;
    restart_generation_next = restart_generation;
    status_seen_next        = status_seen;
    restart_queued_next     = restart_queued;
    armed_action_next       = armed_action;
    action_issued_time_next = action_issued_time;
    probes_done_next        = probes_done;
    last_probe_time_next    = last_probe_time;
    uart_reinit_done_next   = uart_reinit_done;
    marked_down_next        = marked_down;
    res_boot                = lrs_pkg::BOOT_INVALID;
    res_restart             = lrs_pkg::RR_BAD_BOOT;
    res_action              = lrs_pkg::ACT_NONE;
    res_complete            = 1'b0;

    unique case (opcode)
      lrs_pkg::OP_START: begin
        monitor_start_next      = now_ms;
        last_status_time_next   = '0;
        partner_boot_next       = '0;
        restart_generation_next = '0;
        status_seen_next        = 1'b0;
        restart_queued_next     = 1'b0;
        armed_action_next       = lrs_pkg::ACT_NONE;
        action_issued_time_next = '0;
        probes_done_next        = '0;
        last_probe_time_next    = '0;
        uart_reinit_done_next   = 1'b0;
        marked_down_next        = 1'b0;
      end

      lrs_pkg::OP_STATUS: begin
        if ((boot_id != '0) && time_ok) begin
          if (!status_seen || (boot_id != partner_boot)) begin
            // new partner boot drops remote requests and any pending action
            res_boot                = status_seen ? lrs_pkg::BOOT_CHANGED
                                                  : lrs_pkg::BOOT_FIRST;
            restart_generation_next = '0;
            restart_queued_next     = 1'b0;
            armed_action_next       = lrs_pkg::ACT_NONE;
            action_issued_time_next = '0;
          end else begin
            res_boot = lrs_pkg::BOOT_UNCHANGED;
            if (armed_action != lrs_pkg::ACT_RADIO) begin
              armed_action_next       = lrs_pkg::ACT_NONE;
              action_issued_time_next = '0;
            end
          end
          partner_boot_next     = boot_id;
          last_status_time_next = now_ms;
          status_seen_next      = 1'b1;
          probes_done_next      = '0;
          last_probe_time_next  = '0;
          uart_reinit_done_next = 1'b0;
          marked_down_next      = 1'b0;
        end
      end

      lrs_pkg::OP_RESTART: begin
        if (!status_seen || (boot_id == '0) || (boot_id != partner_boot)) begin
          res_restart = lrs_pkg::RR_BAD_BOOT;
        end else if (generation == '0) begin
          res_restart = lrs_pkg::RR_BAD_GEN;
        end else if (generation < restart_generation) begin
          res_restart = lrs_pkg::RR_STALE;
        end else if (generation == restart_generation) begin
          res_restart = lrs_pkg::RR_REFRESHED;
        end else begin
          res_restart             = lrs_pkg::RR_APPLIED;
          restart_generation_next = generation;
          restart_queued_next     = 1'b1;
        end
      end

      lrs_pkg::OP_TICK: begin
        if (time_ok) begin
          if (silent_x >= CMP_W'(unavailable_after_ms)) begin
            // long silence overrides whatever is pending
            if (!marked_down) begin
              res_action = lrs_pkg::ACT_DOWN;
              if (armed_action != lrs_pkg::ACT_DOWN) begin
                armed_action_next       = lrs_pkg::ACT_DOWN;
                action_issued_time_next = now_ms;
              end
            end
          end else if (armed_action != lrs_pkg::ACT_NONE) begin
            if (!((armed_action == lrs_pkg::ACT_RADIO) && fw_update)) begin
              res_action = armed_action;
            end
          end else if (restart_queued && !fw_update) begin
            res_action              = lrs_pkg::ACT_RADIO;
            armed_action_next       = lrs_pkg::ACT_RADIO;
            action_issued_time_next = now_ms;
          end else if (probe_due) begin
            res_action              = lrs_pkg::ACT_PROBE;
            armed_action_next       = lrs_pkg::ACT_PROBE;
            action_issued_time_next = now_ms;
          end else if (uart_due) begin
            res_action              = lrs_pkg::ACT_UART;
            armed_action_next       = lrs_pkg::ACT_UART;
            action_issued_time_next = now_ms;
          end
        end
      end

      lrs_pkg::OP_COMPLETE: begin
        if ((done_act != lrs_pkg::ACT_NONE) && (done_act == armed_action) &&
            (now_ms >= action_issued_time) && time_ok) begin
          if (!succeeded) begin
            // failed attempt is acknowledged, action stays pending
            res_complete = 1'b1;
          end else begin
            case (armed_action)
              lrs_pkg::ACT_PROBE: begin
                if (probes_done < probe_limit) begin
                  probes_done_next        = probes_done + 1'b1;
                  last_probe_time_next    = now_ms;
                  armed_action_next       = lrs_pkg::ACT_NONE;
                  action_issued_time_next = '0;
                  res_complete            = 1'b1;
                end
              end
              lrs_pkg::ACT_UART: begin
                uart_reinit_done_next   = 1'b1;
                armed_action_next       = lrs_pkg::ACT_NONE;
                action_issued_time_next = '0;
                res_complete            = 1'b1;
              end
              lrs_pkg::ACT_DOWN: begin
                marked_down_next        = 1'b1;
                armed_action_next       = lrs_pkg::ACT_NONE;
                action_issued_time_next = '0;
                res_complete            = 1'b1;
              end
              lrs_pkg::ACT_RADIO: begin
                restart_queued_next     = 1'b0;
                armed_action_next       = lrs_pkg::ACT_NONE;
                action_issued_time_next = '0;
                res_complete            = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
      end

      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stale_after_ms       <= lrs_pkg::STALE_AFTER_RST;
      probe_interval_ms    <= lrs_pkg::PROBE_INTERVAL_RST;
      probe_limit          <= lrs_pkg::PROBE_LIMIT_RST;
      uart_reinit_after_ms <= lrs_pkg::UART_AFTER_RST;
      unavailable_after_ms <= lrs_pkg::UNAVAIL_AFTER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lrs_pkg::REG_STALE_AFTER:    stale_after_ms       <= cfg_data;
        lrs_pkg::REG_PROBE_INTERVAL: probe_interval_ms    <= cfg_data;
        lrs_pkg::REG_PROBE_LIMIT:    probe_limit          <= cfg_data[lrs_pkg::LIMIT_W-1:0];
        lrs_pkg::REG_UART_AFTER:     uart_reinit_after_ms <= cfg_data;
        lrs_pkg::REG_UNAVAIL_AFTER:  unavailable_after_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // supervisor state update on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_start      <= '0;
      last_status_time   <= '0;
      partner_boot       <= '0;
      restart_generation <= '0;
      status_seen        <= 1'b0;
      restart_queued     <= 1'b0;
      armed_action       <= lrs_pkg::ACT_NONE;
      action_issued_time <= '0;
      probes_done        <= '0;
      last_probe_time    <= '0;
      uart_reinit_done   <= 1'b0;
      marked_down        <= 1'b0;
    end else if (in_accept) begin
      monitor_start      <= monitor_start_next;
      last_status_time   <= last_status_time_next;
      partner_boot       <= partner_boot_next;
      restart_generation <= restart_generation_next;
      status_seen        <= status_seen_next;
      restart_queued     <= restart_queued_next;
      armed_action       <= armed_action_next;
      action_issued_time <= action_issued_time_next;
      probes_done        <= probes_done_next;
      last_probe_time    <= last_probe_time_next;
      uart_reinit_done   <= uart_reinit_done_next;
      marked_down        <= marked_down_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      boot_result    <= res_boot;
      restart_result <= res_restart;
      action_now     <= res_action;
      complete_ok    <= res_complete;
    end
  end

  // a tick that orders a probe leaves the probe pending
  a_probe_pending: assert property (@(posedge clk) disable iff (rst)
    in_accept && (res_action == lrs_pkg::ACT_PROBE)
    |=> armed_action == lrs_pkg::ACT_PROBE)
    else $error("probe ordered but not left pending");

  // at most one result field is nonzero
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({boot_result != 2'd0, restart_result != 3'd0,
                              action_now != 3'd0, complete_ok}) <= 1)
    else $error("more than one result field set");

  // probe count never moves on a tick
  a_tick_probes: assert property (@(posedge clk) disable iff (rst)
    in_accept && (opcode == lrs_pkg::OP_TICK) |=> $stable(probes_done))
    else $error("probe count changed on a tick");

  // partner marked down only by an accepted completion
  a_down_by_completion: assert property (@(posedge clk) disable iff (rst)
    $rose(marked_down) |-> $past(in_accept && (opcode == lrs_pkg::OP_COMPLETE)))
    else $error("partner marked down without a completion");

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link recovery supervisor testbench
// Drives timestamped events through the valid/stall channel and configures
// the thresholds through the register write channel. A behavioral model of
// the supervisor predicts one outcome per accepted event, and every result
// transaction is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  // opcodes outside the defined event set
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    lrs_pkg::boot_res_t    boot;
    lrs_pkg::restart_res_t restart;
    lrs_pkg::act_t         act;
    logic                  ok;
  } outcome_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] now;
    logic [31:0] boot;
    logic [31:0] gen;
    logic        ota;
    logic [2:0]  done;
    logic        ok;
    logic        typed;
    outcome_t    want;
  } ev_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [lrs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lrs_pkg::CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [2:0] opcode;
  logic [31:0] now_ms;
  logic [lrs_pkg::ID_W-1:0] boot_id;
  logic [lrs_pkg::ID_W-1:0] generation;
  logic fw_update;
  logic [2:0] done_action;
  logic succeeded;
  logic out_valid;
  logic out_stall;
  logic [1:0] boot_result;
  logic [2:0] restart_result;
  logic [2:0] action_now;
  logic complete_ok;

  // model configuration
  logic [31:0] cfg_stale, cfg_interval, cfg_uart_after, cfg_unavail;
  logic [3:0] cfg_limit;

  // model state
  logic [31:0] mon_t0, last_heard, peer_boot, peer_gen, open_since, last_probe_at;
  logic heard, radio_queued, uart_redone, peer_down;
  lrs_pkg::act_t open_action;
  logic [3:0] probe_count;

  outcome_t awaited[$];
  ev_t queued_rows[$];
  logic [31:0] cur_ms;
  bit steady;
  int errors;

  always #2 clk = ~clk;

  link_recovery_supervisor DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .now_ms(now_ms),
    .boot_id(boot_id),
    .generation(generation),
    .fw_update(fw_update),
    .done_action(done_action),
    .succeeded(succeeded),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .boot_result(boot_result),
    .restart_result(restart_result),
    .action_now(action_now),
    .complete_ok(complete_ok)
  );

  // ---------------------------------------------------------------- model

  function automatic bit in_order(input logic [31:0] t);
    return !(t < mon_t0) && !(heard && t < last_heard);
  endfunction

  // recovery progress cleared by a valid status
  function automatic void drop_local();
    probe_count = '0;
    last_probe_at = '0;
    uart_redone = 1'b0;
    peer_down = 1'b0;
    if (open_action != lrs_pkg::ACT_RADIO) begin
      open_action = lrs_pkg::ACT_NONE;
      open_since = '0;
    end
  endfunction

  function automatic void begin_watch(input logic [31:0] t);
    mon_t0 = t;
    last_heard = '0;
    peer_boot = '0;
    peer_gen = '0;
    heard = 1'b0;
    radio_queued = 1'b0;
    open_action = lrs_pkg::ACT_NONE;
    open_since = '0;
    drop_local();
  endfunction

  function automatic lrs_pkg::act_t open_new(input lrs_pkg::act_t a, input logic [31:0] t);
    open_action = a;
    open_since = t;
    return a;
  endfunction

  // escalation choice for a tick
  function automatic lrs_pkg::act_t tick_action(input logic [31:0] t, input logic ota);
    logic [31:0] silent;
    if (!in_order(t)) return lrs_pkg::ACT_NONE;
    silent = t - (heard ? last_heard : mon_t0);
    if (silent >= cfg_unavail) begin
      if (peer_down) return lrs_pkg::ACT_NONE;
      if (open_action != lrs_pkg::ACT_DOWN) void'(open_new(lrs_pkg::ACT_DOWN, t));
      return open_action;
    end
    if (open_action != lrs_pkg::ACT_NONE)
      return (open_action == lrs_pkg::ACT_RADIO && ota) ? lrs_pkg::ACT_NONE : open_action;
    if (radio_queued && !ota) return open_new(lrs_pkg::ACT_RADIO, t);
    if (probe_count < cfg_limit && silent >= cfg_stale &&
        (probe_count == 0 || (t >= last_probe_at && t - last_probe_at >= cfg_interval)))
      return open_new(lrs_pkg::ACT_PROBE, t);
    if (probe_count == cfg_limit && !uart_redone && silent >= cfg_uart_after)
      return open_new(lrs_pkg::ACT_UART, t);
    return lrs_pkg::ACT_NONE;
  endfunction

  // acceptance of a completion report
  function automatic logic close_action(input logic [2:0] a, input logic ok,
                                        input logic [31:0] t);
    if (a == lrs_pkg::ACT_NONE || a != open_action || t < open_since || !in_order(t))
      return 1'b0;
    if (!ok) return 1'b1;
    case (a)
      lrs_pkg::ACT_PROBE: begin
        if (probe_count >= cfg_limit) return 1'b0;
        probe_count = probe_count + 1'b1;
        last_probe_at = t;
      end
      lrs_pkg::ACT_UART: uart_redone = 1'b1;
      lrs_pkg::ACT_DOWN: peer_down = 1'b1;
      lrs_pkg::ACT_RADIO: radio_queued = 1'b0;
      default: return 1'b0;
    endcase
    open_action = lrs_pkg::ACT_NONE;
    open_since = '0;
    return 1'b1;
  endfunction

  function automatic outcome_t supervise(input ev_t e);
    outcome_t res;
    res = '0;
    case (e.op)
      lrs_pkg::OP_START: begin_watch(e.now);
      lrs_pkg::OP_STATUS: begin
        if (e.boot != 0 && in_order(e.now)) begin
          res.boot = !heard ? lrs_pkg::BOOT_FIRST :
                     (e.boot != peer_boot ? lrs_pkg::BOOT_CHANGED
                                          : lrs_pkg::BOOT_UNCHANGED);
          if (res.boot != lrs_pkg::BOOT_UNCHANGED) begin
            peer_gen = '0;
            radio_queued = 1'b0;
            open_action = lrs_pkg::ACT_NONE;
            open_since = '0;
          end
          peer_boot = e.boot;
          last_heard = e.now;
          heard = 1'b1;
          drop_local();
        end
      end
      lrs_pkg::OP_RESTART: begin
        if (!heard || e.boot == 0 || e.boot != peer_boot)
          res.restart = lrs_pkg::RR_BAD_BOOT;
        else if (e.gen == 0) res.restart = lrs_pkg::RR_BAD_GEN;
        else if (e.gen < peer_gen) res.restart = lrs_pkg::RR_STALE;
        else if (e.gen == peer_gen) res.restart = lrs_pkg::RR_REFRESHED;
        else begin
          peer_gen = e.gen;
          radio_queued = 1'b1;
          res.restart = lrs_pkg::RR_APPLIED;
        end
      end
      lrs_pkg::OP_TICK: res.act = tick_action(e.now, e.ota);
      lrs_pkg::OP_COMPLETE: res.ok = close_action(e.done, e.ok, e.now);
      default: ;
    endcase
    return res;
  endfunction

  function automatic void reset_model();
    cfg_stale = lrs_pkg::STALE_AFTER_RST;
    cfg_interval = lrs_pkg::PROBE_INTERVAL_RST;
    cfg_limit = lrs_pkg::PROBE_LIMIT_RST;
    cfg_uart_after = lrs_pkg::UART_AFTER_RST;
    cfg_unavail = lrs_pkg::UNAVAIL_AFTER_RST;
    begin_watch('0);
  endfunction

  // ------------------------------------------------------------- stimulus

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic ev_t row(input logic [2:0] op, input logic [31:0] t,
                              input logic [31:0] boot, input logic [31:0] gen,
                              input logic ota, input logic [2:0] done, input logic ok);
    ev_t e;
    e = '0;
    e.op = op;
    e.now = t;
    e.boot = boot;
    e.gen = gen;
    e.ota = ota;
    e.done = done;
    e.ok = ok;
    return e;
  endfunction

  // row whose outcome is written out by hand
  function automatic ev_t known(input ev_t e, input lrs_pkg::boot_res_t b,
                                input lrs_pkg::restart_res_t r,
                                input lrs_pkg::act_t a, input logic c);
    e.typed = 1'b1;
    e.want.boot = b;
    e.want.restart = r;
    e.want.act = a;
    e.want.ok = c;
    return e;
  endfunction

  // mostly well-formed traffic around the current peer, with some noise
  function automatic ev_t random_event();
    ev_t e;
    int unsigned pick, r;
    logic [31:0] step;
    pick = $urandom_range(0, 99);
    r = $urandom_range(0, 19);
    if (r < 6) step = $urandom_range(0, 3);
    else if (r < 14) step = $urandom_range(0, 1500);
    else if (r < 19) step = $urandom_range(0, 12000);
    else step = $urandom_range(0, 1 << 20);
    cur_ms = cur_ms + step;
    e = row(lrs_pkg::OP_TICK, cur_ms, $urandom, $urandom, 1'($urandom_range(0, 1)),
            3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    // out-of-order and extreme timestamps
    if ($urandom_range(0, 99) < 6) begin
      case ($urandom_range(0, 3))
        0: e.now = '0;
        1: e.now = '1;
        2: e.now = $urandom;
        default: e.now = cur_ms - $urandom_range(1, 500);
      endcase
    end
    if (pick < 3) begin
      e.op = lrs_pkg::OP_START;
      cur_ms = e.now;
    end else if (pick < 5) begin
      e.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end else if (pick < 15) begin
      e.op = lrs_pkg::OP_STATUS;
      r = $urandom_range(0, 9);
      if (r < 7) e.boot = (peer_boot != 0) ? peer_boot : ($urandom | 32'd1);
      else if (r == 9) e.boot = '0;
    end else if (pick < 27) begin
      e.op = lrs_pkg::OP_RESTART;
      r = $urandom_range(0, 19);
      if (r < 17) e.boot = peer_boot;
      else if (r == 19) e.boot = '0;
      r = $urandom_range(0, 19);
      if (r < 2) e.gen = '0;
      else if (r < 6) e.gen = peer_gen;
      else if (r < 9) e.gen = peer_gen - $urandom_range(0, 3);
      else if (r < 19) e.gen = peer_gen + $urandom_range(1, 3);
    end else if (pick < 65) begin
      e.ota = ($urandom_range(0, 9) < 3);
    end else begin
      e.op = lrs_pkg::OP_COMPLETE;
      if ($urandom_range(0, 3) != 0)
        e.done = (open_action != lrs_pkg::ACT_NONE) ? open_action
                                                    : 3'($urandom_range(1, 4));
      e.ok = ($urandom_range(0, 19) < 17);
    end
    return e;
  endfunction

  // one event transaction, predicted when it is accepted
  task automatic send_event(input ev_t e);
    int gap;
    outcome_t predicted;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= e.op;
    now_ms <= e.now;
    boot_id <= e.boot;
    generation <= e.gen;
    fw_update <= e.ota;
    done_action <= e.done;
    succeeded <= e.ok;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = supervise(e);
    awaited.push_back(e.typed ? e.want : predicted);
  endtask

  task automatic play_rows();
    while (queued_rows.size() != 0) send_event(queued_rows.pop_front());
  endtask

  // hold off the sender until every outcome has drained
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input lrs_pkg::reg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      lrs_pkg::REG_STALE_AFTER: cfg_stale = data;
      lrs_pkg::REG_PROBE_INTERVAL: cfg_interval = data;
      lrs_pkg::REG_PROBE_LIMIT: cfg_limit = data[lrs_pkg::LIMIT_W-1:0];
      lrs_pkg::REG_UART_AFTER: cfg_uart_after = data;
      lrs_pkg::REG_UNAVAIL_AFTER: cfg_unavail = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // full register set, upper bits of the limit write are don't-care
  task automatic program_regs(input logic [31:0] stale, input logic [31:0] interval,
                              input logic [3:0] limit, input logic [31:0] uart,
                              input logic [31:0] unavail);
    settle();
    write_reg(lrs_pkg::REG_STALE_AFTER, stale);
    write_reg(lrs_pkg::REG_PROBE_INTERVAL, interval);
    write_reg(lrs_pkg::REG_PROBE_LIMIT, {28'($urandom), limit});
    write_reg(lrs_pkg::REG_UART_AFTER, uart);
    write_reg(lrs_pkg::REG_UNAVAIL_AFTER, unavail);
  endtask

  task automatic run_random(input int count);
    repeat (count) begin
      if ($urandom_range(0, 49) == 0) steady = !steady;
      if ($urandom_range(0, 59) == 0) settle();
      send_event(random_event());
    end
  endtask

  // ------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic [2:0] got,
                             input logic [2:0] exp);
    if (got !== exp) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, got);
      errors++;
    end
  endtask

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d", $time,
                 boot_result, restart_result, action_now, complete_ok);
        errors++;
      end else begin
        want = awaited.pop_front();
        check_field("boot_result", {1'b0, boot_result}, {1'b0, want.boot});
        check_field("restart_result", restart_result, want.restart);
        check_field("action_now", action_now, want.act);
        check_field("complete_ok", {2'b00, complete_ok}, {2'b00, want.ok});
      end
    end
  end

  // result side back-pressure
  initial begin : result_stall
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      n = draw_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall) || rst);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    #(2_000_000);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] s, u, d;
    errors = 0;
    steady = 1'b0;
    cur_ms = '0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = lrs_pkg::REG_STALE_AFTER;
    cfg_data = '0;
    in_valid = 1'b0;
    opcode = lrs_pkg::OP_START;
    now_ms = '0;
    boot_id = '0;
    generation = '0;
    fw_update = 1'b0;
    done_action = lrs_pkg::ACT_NONE;
    succeeded = 1'b0;
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: fresh state with reset configuration
    queued_rows.push_back(known(
        row(lrs_pkg::OP_TICK, 0, 1, 1, 1'b0, lrs_pkg::ACT_NONE, 1'b1),
        lrs_pkg::BOOT_INVALID, lrs_pkg::RR_BAD_BOOT, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(known(
        row(lrs_pkg::OP_STATUS, 10, 0, 1, 1'b0, lrs_pkg::ACT_NONE, 1'b0),
        lrs_pkg::BOOT_INVALID, lrs_pkg::RR_BAD_BOOT, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(known(
        row(lrs_pkg::OP_RESTART, 20, 5, 1, 1'b0, lrs_pkg::ACT_NONE, 1'b0),
        lrs_pkg::BOOT_INVALID, lrs_pkg::RR_BAD_BOOT, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(known(
        row(lrs_pkg::OP_STATUS, 100, '1, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0),
        lrs_pkg::BOOT_FIRST, lrs_pkg::RR_BAD_BOOT, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(known(
        row(lrs_pkg::OP_STATUS, 200, '1, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0),
        lrs_pkg::BOOT_UNCHANGED, lrs_pkg::RR_BAD_BOOT, lrs_pkg::ACT_NONE, 1'b0));
    // timestamp behind the last status
    queued_rows.push_back(known(
        row(lrs_pkg::OP_STATUS, 50, 1, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0),
        lrs_pkg::BOOT_INVALID, lrs_pkg::RR_BAD_BOOT, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(known(
        row(lrs_pkg::OP_RESTART, 210, '1, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0),
        lrs_pkg::BOOT_INVALID, lrs_pkg::RR_BAD_GEN, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(known(
        row(lrs_pkg::OP_RESTART, 210, '1, 7, 1'b0, lrs_pkg::ACT_NONE, 1'b0),
        lrs_pkg::BOOT_INVALID, lrs_pkg::RR_APPLIED, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(known(
        row(lrs_pkg::OP_RESTART, 210, '1, 7, 1'b0, lrs_pkg::ACT_NONE, 1'b0),
        lrs_pkg::BOOT_INVALID, lrs_pkg::RR_REFRESHED, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(known(
        row(lrs_pkg::OP_RESTART, 210, '1, 3, 1'b0, lrs_pkg::ACT_NONE, 1'b0),
        lrs_pkg::BOOT_INVALID, lrs_pkg::RR_STALE, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(known(
        row(lrs_pkg::OP_RESTART, 210, '1, '1, 1'b0, lrs_pkg::ACT_NONE, 1'b0),
        lrs_pkg::BOOT_INVALID, lrs_pkg::RR_APPLIED, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(known(
        row(lrs_pkg::OP_RESTART, 210, 2, 9, 1'b0, lrs_pkg::ACT_NONE, 1'b0),
        lrs_pkg::BOOT_INVALID, lrs_pkg::RR_BAD_BOOT, lrs_pkg::ACT_NONE, 1'b0));
    // radio restart held by ota, then issued, failed, mismatched, done
    queued_rows.push_back(row(lrs_pkg::OP_TICK, 300, 0, 0, 1'b1, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(row(lrs_pkg::OP_TICK, 300, 0, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(row(lrs_pkg::OP_COMPLETE, 310, 0, 0, 1'b0,
                              lrs_pkg::ACT_RADIO, 1'b0));
    queued_rows.push_back(known(
        row(lrs_pkg::OP_COMPLETE, 320, 0, 0, 1'b0, lrs_pkg::ACT_PROBE, 1'b1),
        lrs_pkg::BOOT_INVALID, lrs_pkg::RR_BAD_BOOT, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(row(lrs_pkg::OP_COMPLETE, 320, 0, 0, 1'b0,
                              lrs_pkg::ACT_RADIO, 1'b1));
    // silence escalation: probe, spacing, unavailable
    queued_rows.push_back(row(lrs_pkg::OP_TICK, 5200, 0, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(row(lrs_pkg::OP_COMPLETE, 5300, 0, 0, 1'b0,
                              lrs_pkg::ACT_PROBE, 1'b1));
    queued_rows.push_back(row(lrs_pkg::OP_TICK, 5400, 0, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(row(lrs_pkg::OP_TICK, 30200, 0, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(row(lrs_pkg::OP_COMPLETE, 30300, 0, 0, 1'b0,
                              lrs_pkg::ACT_DOWN, 1'b1));
    queued_rows.push_back(row(lrs_pkg::OP_TICK, 30400, 0, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(known(
        row(lrs_pkg::OP_STATUS, 30500, 1234, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0),
        lrs_pkg::BOOT_CHANGED, lrs_pkg::RR_BAD_BOOT, lrs_pkg::ACT_NONE, 1'b0));
    // undefined opcode leaves everything alone
    queued_rows.push_back(known(
        row(OP_UNUSED_HI, 7, '1, '1, 1'b1, 3'($urandom_range(5, 7)), 1'b1),
        lrs_pkg::BOOT_INVALID, lrs_pkg::RR_BAD_BOOT, lrs_pkg::ACT_NONE, 1'b0));
    // restart monitoring near the top of the time range
    queued_rows.push_back(known(
        row(lrs_pkg::OP_START, 32'hFFFF_FFF0, 0, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0),
        lrs_pkg::BOOT_INVALID, lrs_pkg::RR_BAD_BOOT, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(row(lrs_pkg::OP_TICK, '1, 0, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(known(
        row(lrs_pkg::OP_TICK, 0, 0, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0),
        lrs_pkg::BOOT_INVALID, lrs_pkg::RR_BAD_BOOT, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(row(lrs_pkg::OP_START, 0, 0, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0));
    play_rows();

    // random traffic with reset thresholds
    run_random(250);

    // probe limit lowered under the current probe count
    program_regs('0, '0, 4'd15, '0, '1);
    queued_rows.push_back(row(lrs_pkg::OP_START, 1000, 0, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(row(lrs_pkg::OP_TICK, 1000, 0, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(row(lrs_pkg::OP_COMPLETE, 1000, 0, 0, 1'b0,
                              lrs_pkg::ACT_PROBE, 1'b1));
    queued_rows.push_back(row(lrs_pkg::OP_TICK, 1001, 0, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(row(lrs_pkg::OP_COMPLETE, 1001, 0, 0, 1'b0,
                              lrs_pkg::ACT_PROBE, 1'b1));
    queued_rows.push_back(row(lrs_pkg::OP_TICK, 1002, 0, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(row(lrs_pkg::OP_COMPLETE, 1002, 0, 0, 1'b0,
                              lrs_pkg::ACT_PROBE, 1'b1));
    play_rows();
    settle();
    write_reg(lrs_pkg::REG_PROBE_LIMIT, {28'($urandom), 4'd2});
    queued_rows.push_back(row(lrs_pkg::OP_TICK, 1003, 0, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0));
    play_rows();
    // probe pending while the limit drops to the count
    settle();
    write_reg(lrs_pkg::REG_PROBE_LIMIT, {28'($urandom), 4'd15});
    queued_rows.push_back(row(lrs_pkg::OP_TICK, 1005, 0, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0));
    play_rows();
    settle();
    write_reg(lrs_pkg::REG_PROBE_LIMIT, {28'($urandom), 4'd3});
    queued_rows.push_back(row(lrs_pkg::OP_COMPLETE, 1006, 0, 0, 1'b0,
                              lrs_pkg::ACT_PROBE, 1'b1));
    queued_rows.push_back(row(lrs_pkg::OP_TICK, 1007, 0, 0, 1'b0, lrs_pkg::ACT_NONE, 1'b0));
    queued_rows.push_back(row(lrs_pkg::OP_STATUS, 1008, 77, 0, 1'b0,
                              lrs_pkg::ACT_NONE, 1'b0));
    play_rows();
    cur_ms = 1008;

    // all thresholds at zero
    program_regs('0, '0, 4'd0, '0, '0);
    steady = 1'b1;
    run_random(150);

    // all thresholds at their maximum
    program_regs('1, '1, 4'd15, '1, '1);
    run_random(150);

    // assorted moderate settings
    repeat (4) begin
      s = $urandom_range(0, 3000);
      u = s + $urandom_range(0, 8000);
      d = u + $urandom_range(0, 20000);
      program_regs(s, $urandom_range(0, 1500),
                   ($urandom_range(0, 6) == 0) ? 4'd15 : 4'($urandom_range(0, 6)), u, d);
      run_random(175);
    end

    settle();
    repeat (4) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
